[src/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OBPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define OBPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/obpa_pkg.sv]
// Types, widths and constants of the OHLC bar period aggregator.
`default_nettype none

package obpa_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DOM_W    = 5;
    localparam int PRICE_W  = 32;
    localparam int VOL_IN_W = 32;
    localparam int VOL_W    = 48;
    localparam int NUM_W    = 16;
    localparam int MODE_W   = 2;

    localparam int SER_W  = 21;
    localparam int YY_W   = 13;
    localparam int C_W    = 7;
    localparam int X_W    = 13;
    localparam int OFS_W  = 9;
    localparam int WD_W   = 3;
    localparam int MKEY_W = YEAR_W + MONTH_W;

    localparam int OUT_DEPTH = 4;

    localparam logic [MODE_W-1:0] MODE_WEEK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MONTH = 2'd2;

    localparam logic [VOL_W-1:0] VOL_MAX = '1;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DOM_W-1:0]    dom;
        logic [PRICE_W-1:0]  open;
        logic [PRICE_W-1:0]  high;
        logic [PRICE_W-1:0]  low;
        logic [PRICE_W-1:0]  close;
        logic [VOL_IN_W-1:0] volume;
        logic                last;
    } day_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   dom;
        logic [PRICE_W-1:0] open;
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] close;
        logic [VOL_W-1:0]   volume;
        logic [NUM_W-1:0]   number;
        logic               final_bar;
    } bar_t;

    typedef struct packed {
        day_t              day;
        logic [SER_W-1:0]  wkey;
        logic [MKEY_W-1:0] mkey;
    } keyed_day_t;

    typedef struct packed {
        logic a_valid;
        bar_t a;
        logic b_valid;
        bar_t b;
    } bar_pair_t;

    // Days from March 1 to the first of the month (March-based year).
    function automatic logic [OFS_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [OFS_W-1:0] ofs;
        unique case (m)
            4'd1:    ofs = 9'd306;
            4'd2:    ofs = 9'd337;
            4'd3:    ofs = 9'd0;
            4'd4:    ofs = 9'd31;
            4'd5:    ofs = 9'd61;
            4'd6:    ofs = 9'd92;
            4'd7:    ofs = 9'd122;
            4'd8:    ofs = 9'd153;
            4'd9:    ofs = 9'd184;
            4'd10:   ofs = 9'd214;
            4'd11:   ofs = 9'd245;
            4'd12:   ofs = 9'd275;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

`default_nettype wire

[src/obpa_if.sv]
// Valid/ready channel interfaces for daily input words and bar output words.
`default_nettype none

interface obpa_day_if;
    import obpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   day_year;
    logic [MONTH_W-1:0]  day_month;
    logic [DOM_W-1:0]    day_of_month;
    logic [PRICE_W-1:0]  day_open;
    logic [PRICE_W-1:0]  day_high;
    logic [PRICE_W-1:0]  day_low;
    logic [PRICE_W-1:0]  day_close;
    logic [VOL_IN_W-1:0] day_volume;
    logic                last_day;

    modport source (
        output valid, day_year, day_month, day_of_month, day_open, day_high,
               day_low, day_close, day_volume, last_day,
        input  ready
    );

    modport sink (
        input  valid, day_year, day_month, day_of_month, day_open, day_high,
               day_low, day_close, day_volume, last_day,
        output ready
    );
endinterface

interface obpa_bar_if;
    import obpa_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  bar_year;
    logic [MONTH_W-1:0] bar_month;
    logic [DOM_W-1:0]   bar_day;
    logic [PRICE_W-1:0] bar_open;
    logic [PRICE_W-1:0] bar_high;
    logic [PRICE_W-1:0] bar_low;
    logic [PRICE_W-1:0] bar_close;
    logic [VOL_W-1:0]   bar_volume;
    logic [NUM_W-1:0]   bar_number;
    logic               final_bar;

    modport source (
        output valid, bar_year, bar_month, bar_day, bar_open, bar_high, bar_low,
               bar_close, bar_volume, bar_number, final_bar,
        input  ready
    );

    modport sink (
        input  valid, bar_year, bar_month, bar_day, bar_open, bar_high, bar_low,
               bar_close, bar_volume, bar_number, final_bar,
        output ready
    );
endinterface

`default_nettype wire

[src/obpa_key_calc.sv]
// Input register and three-stage pipeline computing the week and month period keys.
`default_nettype none

module obpa_key_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  obpa_pkg::day_t      in_day,
    output logic                out_valid,
    output obpa_pkg::keyed_day_t out_word
);
    import obpa_pkg::*;

    localparam logic [YY_W-1:0] YEAR_BIAS = 13'd400;
    localparam int C_MUL    = 5243;   // ~2^19/100
    localparam int C_SHIFT  = 19;
    localparam int CP_W     = YY_W + 14;
    localparam int W_MUL    = 9363;   // ~2^16/7
    localparam int W_SHIFT  = 16;
    localparam int WP_W     = X_W + 14;
    localparam int Q_W      = WP_W - W_SHIFT;
    localparam int DAYS_YR  = 365;

    // input register
    logic       r_valid_reg;
    day_t       r_day_reg;

    // stage 1: shifted year, century count, month offset
    logic                 s1_valid_reg;
    day_t                 s1_day_reg;
    logic [YY_W-1:0]      s1_yy_reg;
    logic [C_W-1:0]       s1_c_reg;
    logic [OFS_W-1:0]     s1_ofs_reg;

    // stage 2: serial day and weekday sum
    logic                 s2_valid_reg;
    day_t                 s2_day_reg;
    logic [SER_W-1:0]     s2_ser_reg;
    logic [X_W-1:0]       s2_x_reg;

    // stage 3: keys
    logic                 k_valid_reg;
    keyed_day_t           k_word_reg;

    logic [MONTH_W-1:0]   m_clamp;
    logic                 early_month;
    logic [YY_W-1:0]      yy_next;
    logic [CP_W-1:0]      c_prod;
    logic [SER_W-1:0]     ser_next;
    logic [X_W-1:0]       x_next;
    logic [WP_W-1:0]      w_prod;
    logic [Q_W-1:0]       q_week;
    logic [X_W-1:0]       x_rem;
    logic [WD_W-1:0]      wday;
    keyed_day_t           k_word_next;

    always_comb
    begin
        if (r_day_reg.month == 4'd0)
        begin
            m_clamp = 4'd1;
        end
        else if (r_day_reg.month > 4'd12)
        begin
            m_clamp = 4'd12;
        end
        else
        begin
            m_clamp = r_day_reg.month;
        end
        early_month = (m_clamp <= 4'd2);
        yy_next = YY_W'(r_day_reg.year) + YEAR_BIAS - YY_W'(early_month);
        c_prod  = CP_W'(yy_next) * CP_W'(C_MUL);
    end

    always_comb
    begin
        ser_next = SER_W'(s1_yy_reg) * SER_W'(DAYS_YR)
                 + SER_W'(s1_yy_reg >> 2) - SER_W'(s1_c_reg) + SER_W'(s1_c_reg >> 2)
                 + SER_W'(s1_ofs_reg) + SER_W'(s1_day_reg.dom) - SER_W'(1);
        x_next   = X_W'(s1_yy_reg) + X_W'(s1_yy_reg >> 2) - X_W'(s1_c_reg)
                 + X_W'(s1_c_reg >> 2) + X_W'(s1_ofs_reg) + X_W'(s1_day_reg.dom)
                 + X_W'(1);
    end

    always_comb
    begin
        w_prod = WP_W'(s2_x_reg) * WP_W'(W_MUL);
        q_week = w_prod[W_SHIFT +: Q_W];
        x_rem  = s2_x_reg - X_W'(q_week) * X_W'(7);
        wday   = x_rem[WD_W-1:0];
        k_word_next.day  = s2_day_reg;
        k_word_next.wkey = s2_ser_reg - SER_W'(wday);
        k_word_next.mkey = {s2_day_reg.year, s2_day_reg.month};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            k_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            r_valid_reg  <= in_valid;
            s1_valid_reg <= r_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            k_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_day_reg  <= in_day;
            s1_day_reg <= r_day_reg;
            s1_yy_reg  <= yy_next;
            s1_c_reg   <= c_prod[C_SHIFT +: C_W];
            s1_ofs_reg <= month_offset(m_clamp);
            s2_day_reg <= s1_day_reg;
            s2_ser_reg <= ser_next;
            s2_x_reg   <= x_next;
            k_word_reg <= k_word_next;
        end
    end

    assign out_valid = k_valid_reg;
    assign out_word  = k_word_reg;

endmodule

`default_nettype wire

[src/obpa_merge.sv]
// Pending bar state: period compare, OHLCV merge and result generation.
`default_nettype none

module obpa_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  obpa_pkg::keyed_day_t        in_word,
    input  logic [obpa_pkg::MODE_W-1:0] period_mode,
    output obpa_pkg::bar_pair_t         push
);
    import obpa_pkg::*;

    logic                pend_valid_reg;
    logic [NUM_W-1:0]    count_reg;
    logic [YEAR_W-1:0]   pend_year_reg;
    logic [MONTH_W-1:0]  pend_month_reg;
    logic [DOM_W-1:0]    pend_dom_reg;
    logic [PRICE_W-1:0]  pend_open_reg;
    logic [PRICE_W-1:0]  pend_high_reg;
    logic [PRICE_W-1:0]  pend_low_reg;
    logic [PRICE_W-1:0]  pend_close_reg;
    logic [VOL_W-1:0]    pend_vol_reg;
    logic [SER_W-1:0]    pend_wkey_reg;
    logic [MKEY_W-1:0]   pend_mkey_reg;

    day_t                day;
    logic                key_diff;
    logic                close_first;
    logic                extend;
    logic [NUM_W-1:0]    cnt_after;
    logic [VOL_W:0]      vol_sum;
    logic [PRICE_W-1:0]  open_next;
    logic [PRICE_W-1:0]  high_next;
    logic [PRICE_W-1:0]  low_next;
    logic [VOL_W-1:0]    vol_next;

    always_comb
    begin
        day = in_word.day;
        if (period_mode == MODE_MONTH)
        begin
            key_diff = (pend_mkey_reg != in_word.mkey);
        end
        else
        begin
            key_diff = (pend_wkey_reg != in_word.wkey);
        end
        close_first = pend_valid_reg && key_diff;
        extend      = pend_valid_reg && !key_diff;
        cnt_after   = close_first ? count_reg + NUM_W'(1) : count_reg;

        vol_sum   = {1'b0, pend_vol_reg} + (VOL_W + 1)'(day.volume);
        open_next = extend ? pend_open_reg : day.open;
        high_next = (extend && !(day.high > pend_high_reg)) ? pend_high_reg : day.high;
        low_next  = (extend && !(day.low < pend_low_reg)) ? pend_low_reg : day.low;
        if (extend)
        begin
            vol_next = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
        end
        else
        begin
            vol_next = VOL_W'(day.volume);
        end

        push.a_valid     = take && close_first;
        push.a.year      = pend_year_reg;
        push.a.month     = pend_month_reg;
        push.a.dom       = pend_dom_reg;
        push.a.open      = pend_open_reg;
        push.a.high      = pend_high_reg;
        push.a.low       = pend_low_reg;
        push.a.close     = pend_close_reg;
        push.a.volume    = pend_vol_reg;
        push.a.number    = count_reg;
        push.a.final_bar = !day.last;

        push.b_valid     = take && day.last;
        push.b.year      = day.year;
        push.b.month     = day.month;
        push.b.dom       = day.dom;
        push.b.open      = open_next;
        push.b.high      = high_next;
        push.b.low       = low_next;
        push.b.close     = day.close;
        push.b.volume    = vol_next;
        push.b.number    = cnt_after;
        push.b.final_bar = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (take)
        begin
            pend_valid_reg <= !day.last;
            count_reg      <= day.last ? '0 : cnt_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_year_reg  <= day.year;
            pend_month_reg <= day.month;
            pend_dom_reg   <= day.dom;
            pend_open_reg  <= open_next;
            pend_high_reg  <= high_next;
            pend_low_reg   <= low_next;
            pend_close_reg <= day.close;
            pend_vol_reg   <= vol_next;
            pend_wkey_reg  <= in_word.wkey;
            pend_mkey_reg  <= in_word.mkey;
        end
    end

endmodule

`default_nettype wire

[src/obpa_out_fifo.sv]
// Output queue taking up to two bar words per cycle and delivering one per cycle while out_ready is high.
`default_nettype none

module obpa_out_fifo #(
    parameter int DEPTH = obpa_pkg::OUT_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  obpa_pkg::bar_pair_t push,
    output logic                room2,
    output logic                out_valid,
    input  logic                out_ready,
    output obpa_pkg::bar_t      out_bar
);
    import obpa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bar_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;

    logic [PTR_W-1:0] b_idx;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        pop   = out_valid && out_ready;
        b_idx = push.a_valid ? next_ptr(tail_reg) : tail_reg;
        if (push.a_valid && push.b_valid)
        begin
            tail_next = next_ptr(next_ptr(tail_reg));
        end
        else if (push.a_valid || push.b_valid)
        begin
            tail_next = next_ptr(tail_reg);
        end
        else
        begin
            tail_next = tail_reg;
        end
        count_next = count_reg + CNT_W'(push.a_valid) + CNT_W'(push.b_valid)
                   - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                head_reg <= next_ptr(head_reg);
            end
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.a_valid)
        begin
            mem_reg[tail_reg] <= push.a;
        end
        if (push.b_valid)
        begin
            mem_reg[b_idx] <= push.b;
        end
    end

    assign room2     = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_bar   = mem_reg[head_reg];

endmodule

`default_nettype wire

[src/ohlc_bar_period_aggregator.sv]
// A daily word passes the input register and key stages 1 to 3, then the merge pushes its bars to the queue.
// One daily word per cycle while the pipeline does not stall; the queue takes the up to two bars
// of a word at once and drains one bar per cycle, so words producing two bars are held back by the drain.
// The pipeline stalls while a keyed word waits and the queue has fewer than two free entries.
// Reset (rst_n low, asynchronous): no pending bar, bar number 0, queue empty,
// period_mode set to ISO week grouping.
`default_nettype none

module ohlc_bar_period_aggregator #(
    parameter int OUT_DEPTH = obpa_pkg::OUT_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        period_mode_we,
    input  logic [obpa_pkg::MODE_W-1:0] period_mode_wdata,
    obpa_day_if.sink                    day_in,
    obpa_bar_if.source                  bar_out
);
    import obpa_pkg::*;

    logic [MODE_W-1:0] mode_reg;

    day_t       in_day;
    logic       key_valid;
    keyed_day_t key_word;
    logic       room2;
    logic       en;
    logic       take;
    bar_pair_t  push;
    bar_t       head_bar;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_WEEK;
        end
        else if (period_mode_we)
        begin
            mode_reg <= period_mode_wdata;
        end
    end

    assign en   = !key_valid || room2;
    assign take = key_valid && room2;

    assign day_in.ready = en;

    assign in_day.year   = day_in.day_year;
    assign in_day.month  = day_in.day_month;
    assign in_day.dom    = day_in.day_of_month;
    assign in_day.open   = day_in.day_open;
    assign in_day.high   = day_in.day_high;
    assign in_day.low    = day_in.day_low;
    assign in_day.close  = day_in.day_close;
    assign in_day.volume = day_in.day_volume;
    assign in_day.last   = day_in.last_day;

    obpa_key_calc u_key_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (day_in.valid),
        .in_day    (in_day),
        .out_valid (key_valid),
        .out_word  (key_word)
    );

    obpa_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .in_word     (key_word),
        .period_mode (mode_reg),
        .push        (push)
    );

    obpa_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (bar_out.valid),
        .out_ready (bar_out.ready),
        .out_bar   (head_bar)
    );

    assign bar_out.bar_year   = head_bar.year;
    assign bar_out.bar_month  = head_bar.month;
    assign bar_out.bar_day    = head_bar.dom;
    assign bar_out.bar_open   = head_bar.open;
    assign bar_out.bar_high   = head_bar.high;
    assign bar_out.bar_low    = head_bar.low;
    assign bar_out.bar_close  = head_bar.close;
    assign bar_out.bar_volume = head_bar.volume;
    assign bar_out.bar_number = head_bar.number;
    assign bar_out.final_bar  = head_bar.final_bar;

endmodule

`default_nettype wire

[src/obpa_checker.sv]
// Port-level checker for the aggregator and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module obpa_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       out_final,
    input  logic [obpa_pkg::NUM_W-1:0] out_number,
    input  logic [obpa_pkg::PRICE_W-1:0] out_close
);
    import obpa_pkg::*;

    // empty output queue always has room
    `OBPA_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_valid, in_ready)

    // second bar of a pair is already queued
    `OBPA_ASSERT_NXT(a_pair_follows, clk, rst_n, out_valid && out_ready && !out_final, out_valid)

    `OBPA_ASSERT_NXT(a_pair_number, clk, rst_n, out_valid && out_ready && !out_final, out_number == NUM_W'($past(out_number) + NUM_W'(1)))

    `OBPA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_number) && $stable(out_close))

endmodule

bind ohlc_bar_period_aggregator obpa_checker u_obpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (day_in.ready),
    .out_valid  (bar_out.valid),
    .out_ready  (bar_out.ready),
    .out_final  (bar_out.final_bar),
    .out_number (bar_out.bar_number),
    .out_close  (bar_out.bar_close)
);

`default_nettype wire

[sim/tb_ohlc_bar_period_aggregator.sv]
// Self-checking testbench for the OHLC bar period aggregator: directed and random daily words.
`default_nettype none

module tb_ohlc_bar_period_aggregator;
    import obpa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 12;
    localparam int REPORT_MAX     = 10;

    logic clk;
    logic rst_n;
    logic period_mode_we;
    logic [MODE_W-1:0] period_mode_wdata;

    obpa_day_if day_if ();
    obpa_bar_if bar_if ();

    ohlc_bar_period_aggregator dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .period_mode_we    (period_mode_we),
        .period_mode_wdata (period_mode_wdata),
        .day_in            (day_if),
        .bar_out           (bar_if)
    );

    // shared traffic controls
    logic idle_on;
    logic hold_request;
    int   quiet_cycles;

    // expected bars and mismatch bookkeeping
    bar_t bars_due[$];
    int   bar_mismatches;
    int   bars_seen;

    // shadow of the bar being built
    logic [MODE_W-1:0] period_sel;
    logic              run_open;
    bar_t              run_bar;
    logic [NUM_W-1:0]  bar_count;

    // calendar walk for well-formed day sequences
    int walk_y;
    int walk_m;
    int walk_d;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int unsigned day_serial(input logic [YEAR_W-1:0] y,
                                               input logic [MONTH_W-1:0] m,
                                               input logic [DOM_W-1:0] d);
        int unsigned mm;
        int unsigned yy;
        int unsigned mp;
        mm = (m < 1) ? 1 : ((m > 12) ? 12 : int'(m));
        yy = int'(y) + 400 - ((mm <= 2) ? 1 : 0);
        mp = (mm + 9) % 12;
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5
               + int'(d) - 1;
    endfunction

    // month: (year, month) pair; any other mode: serial day of the week's Monday
    function automatic int unsigned bar_period(input logic [YEAR_W-1:0] y,
                                               input logic [MONTH_W-1:0] m,
                                               input logic [DOM_W-1:0] d);
        int unsigned s;
        if (period_sel == MODE_MONTH)
            return int'(y) * 16 + int'(m);
        s = day_serial(y, m, d);
        return s - (s + 2) % 7;
    endfunction

    function automatic bar_t take_bar();
        bar_t b;
        b = run_bar;
        b.number = bar_count;
        b.final_bar = 1'b0;
        bar_count = bar_count + 1'b1;
        return b;
    endfunction

    task automatic roll_day_into_bar(input day_t d);
        bar_t out_bars[2];
        int n;
        logic [VOL_W:0] vsum;
        n = 0;
        if (run_open && bar_period(run_bar.year, run_bar.month, run_bar.dom)
                        != bar_period(d.year, d.month, d.dom))
        begin
            out_bars[n] = take_bar();
            n++;
            run_open = 1'b0;
        end
        if (!run_open)
        begin
            run_open = 1'b1;
            run_bar.open = d.open;
            run_bar.high = d.high;
            run_bar.low = d.low;
            run_bar.volume = {{(VOL_W-VOL_IN_W){1'b0}}, d.volume};
        end
        else
        begin
            if (d.high > run_bar.high)
                run_bar.high = d.high;
            if (d.low < run_bar.low)
                run_bar.low = d.low;
            vsum = {1'b0, run_bar.volume} + d.volume;
            run_bar.volume = (vsum > VOL_MAX) ? VOL_MAX : vsum[VOL_W-1:0];
        end
        run_bar.year = d.year;
        run_bar.month = d.month;
        run_bar.dom = d.dom;
        run_bar.close = d.close;
        if (d.last)
        begin
            out_bars[n] = take_bar();
            n++;
            run_open = 1'b0;
            bar_count = '0;
        end
        if (n > 0)
            out_bars[n-1].final_bar = 1'b1;
        for (int i = 0; i < n; i++)
            bars_due.push_back(out_bars[i]);
    endtask

    function automatic string bar_text(input bar_t b);
        return $sformatf("%0d-%0d-%0d o=%h h=%h l=%h c=%h v=%h n=%0d f=%b",
                         b.year, b.month, b.dom, b.open, b.high, b.low, b.close,
                         b.volume, b.number, b.final_bar);
    endfunction

    always @(posedge clk)
    begin : bar_check
        bar_t got;
        bar_t want;
        string diff;
        if (rst_n && bar_if.valid && bar_if.ready)
        begin
            got.year = bar_if.bar_year;
            got.month = bar_if.bar_month;
            got.dom = bar_if.bar_day;
            got.open = bar_if.bar_open;
            got.high = bar_if.bar_high;
            got.low = bar_if.bar_low;
            got.close = bar_if.bar_close;
            got.volume = bar_if.bar_volume;
            got.number = bar_if.bar_number;
            got.final_bar = bar_if.final_bar;
            if (bars_due.size() == 0)
            begin
                bar_mismatches++;
                if (bar_mismatches <= REPORT_MAX)
                    $display("bar word %0d not expected: %s", bars_seen, bar_text(got));
            end
            else
            begin
                want = bars_due.pop_front();
                diff = "";
                if (got.year !== want.year) diff = {diff, " year"};
                if (got.month !== want.month) diff = {diff, " month"};
                if (got.dom !== want.dom) diff = {diff, " day"};
                if (got.open !== want.open) diff = {diff, " open"};
                if (got.high !== want.high) diff = {diff, " high"};
                if (got.low !== want.low) diff = {diff, " low"};
                if (got.close !== want.close) diff = {diff, " close"};
                if (got.volume !== want.volume) diff = {diff, " volume"};
                if (got.number !== want.number) diff = {diff, " number"};
                if (got.final_bar !== want.final_bar) diff = {diff, " final_bar"};
                if (diff != "")
                begin
                    bar_mismatches++;
                    if (bar_mismatches <= REPORT_MAX)
                    begin
                        $display("bar word %0d mismatch in%s", bars_seen, diff);
                        $display("  expected %s", bar_text(want));
                        $display("  actual   %s", bar_text(got));
                    end
                end
            end
            bars_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (day_if.valid && day_if.ready) || (bar_if.valid && bar_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : bar_sink
        bar_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                bar_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                bar_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            bar_if.ready <= 1'b1;
        end
    end

    function automatic day_t make_day(input logic [YEAR_W-1:0] y,
                                      input logic [MONTH_W-1:0] m,
                                      input logic [DOM_W-1:0] dom,
                                      input logic [PRICE_W-1:0] o,
                                      input logic [PRICE_W-1:0] h,
                                      input logic [PRICE_W-1:0] l,
                                      input logic [PRICE_W-1:0] c,
                                      input logic [VOL_IN_W-1:0] v,
                                      input logic last);
        day_t d;
        d.year = y;
        d.month = m;
        d.dom = dom;
        d.open = o;
        d.high = h;
        d.low = l;
        d.close = c;
        d.volume = v;
        d.last = last;
        return d;
    endfunction

    function automatic logic [31:0] rand_ticks();
        unique case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int month_days(input int y, input int m);
        if (m == 2)
            return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    task automatic step_calendar(input int n);
        repeat (n)
        begin
            walk_d++;
            if (walk_d > month_days(walk_y, walk_m))
            begin
                walk_d = 1;
                walk_m++;
                if (walk_m > 12)
                begin
                    walk_m = 1;
                    walk_y++;
                end
            end
        end
    endtask

    task automatic restart_calendar();
        walk_y = $urandom_range(1900, 2100);
        walk_m = $urandom_range(1, 12);
        walk_d = $urandom_range(1, month_days(walk_y, walk_m));
    endtask

    function automatic day_t walk_day(input logic last);
        return make_day(YEAR_W'(walk_y), MONTH_W'(walk_m), DOM_W'(walk_d), rand_ticks(),
                        rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(), last);
    endfunction

    task automatic send_day(input day_t d);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            day_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        day_if.valid <= 1'b1;
        day_if.day_year <= d.year;
        day_if.day_month <= d.month;
        day_if.day_of_month <= d.dom;
        day_if.day_open <= d.open;
        day_if.day_high <= d.high;
        day_if.day_low <= d.low;
        day_if.day_close <= d.close;
        day_if.day_volume <= d.volume;
        day_if.last_day <= d.last;
        do @(posedge clk); while (day_if.ready !== 1'b1);
        roll_day_into_bar(d);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] mode);
        day_if.valid <= 1'b0;
        while (bars_due.size() != 0) @(posedge clk);
        // words that close no bar may still be in flight
        repeat (8) @(posedge clk);
        period_mode_we <= 1'b1;
        period_mode_wdata <= mode;
        @(posedge clk);
        period_mode_we <= 1'b0;
        period_sel = mode;
    endtask

    task automatic test_week_grouping();
        set_mode(MODE_WEEK);
        send_day(make_day(2024, 1, 1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h10,
                          32'hFFFF_FFFF, 1'b0));
        send_day(make_day(2024, 1, 3, 32'h5, 32'hFFFF_FFFF, 32'h0, 32'h20,
                          32'hFFFF_FFFF, 1'b0));
        send_day(make_day(2024, 1, 5, 32'h7, 32'h8, 32'h6, 32'h0, 32'h0, 1'b0));
        send_day(make_day(2024, 1, 8, 32'h100, 32'h200, 32'h50, 32'h150, 32'h3, 1'b0));
        send_day(make_day(2024, 1, 14, 32'h0, 32'h300, 32'h40, 32'h160, 32'h4, 1'b0));
        send_day(make_day(2024, 1, 15, 32'h9, 32'h9, 32'h9, 32'h9, 32'h9, 1'b1));
        send_day(make_day(2024, 12, 30, 32'h1, 32'h2, 32'h1, 32'h2, 32'h1, 1'b1));
        send_day(make_day(2024, 12, 31, 32'h11, 32'h12, 32'h10, 32'h11, 32'h5, 1'b0));
        send_day(make_day(2025, 1, 1, 32'h12, 32'h19, 32'h0F, 32'h13, 32'h6, 1'b0));
        send_day(make_day(2025, 1, 5, 32'h13, 32'h14, 32'h12, 32'h14, 32'h7, 1'b1));
    endtask

    task automatic test_month_grouping();
        set_mode(MODE_MONTH);
        send_day(make_day(2023, 1, 31, 32'h20, 32'h30, 32'h10, 32'h25, 32'h100, 1'b0));
        send_day(make_day(2023, 2, 1, 32'h21, 32'h31, 32'h11, 32'h26, 32'h101, 1'b0));
        send_day(make_day(2023, 2, 28, 32'h22, 32'h32, 32'h12, 32'h27, 32'h102, 1'b0));
        send_day(make_day(2024, 2, 1, 32'h23, 32'h33, 32'h13, 32'h28, 32'h103, 1'b0));
        send_day(make_day(2024, 2, 29, 32'h24, 32'h34, 32'h14, 32'h29, 32'h104, 1'b1));
    endtask

    // out-of-range calendar fields under the spare mode codes
    task automatic test_odd_dates();
        set_mode(MODE_SPARE_HI);
        send_day(make_day(2000, 0, 0, 32'h1, 32'h2, 32'h1, 32'h2, 32'h1, 1'b0));
        send_day(make_day(2000, 1, 1, 32'h3, 32'h4, 32'h3, 32'h4, 32'h1, 1'b0));
        send_day(make_day(2000, 13, 31, 32'h5, 32'h6, 32'h5, 32'h6, 32'h1, 1'b0));
        send_day(make_day(2000, 15, 31, 32'h7, 32'h8, 32'h7, 32'h8, 32'h1, 1'b0));
        send_day(make_day(0, 2, 31, 32'h9, 32'hA, 32'h9, 32'hA, 32'h1, 1'b0));
        send_day(make_day(4095, 15, 31, 32'hB, 32'hC, 32'hB, 32'hC, 32'h1, 1'b1));
        set_mode(MODE_SPARE_LO);
        send_day(make_day(2010, 6, 7, 32'hD, 32'hE, 32'hD, 32'hE, 32'h1, 1'b0));
        send_day(make_day(2010, 6, 9, 32'hF, 32'h10, 32'hF, 32'h10, 32'h1, 1'b1));
    endtask

    task automatic test_backpressure();
        set_mode(MODE_WEEK);
        restart_calendar();
        hold_request = 1'b1;
        for (int k = 0; k < 40; k++)
        begin
            step_calendar(7);
            send_day(walk_day(1'b0));
        end
    endtask

    task automatic test_random_traffic(input logic [MODE_W-1:0] mode, input int count);
        day_t d;
        int r;
        set_mode(mode);
        restart_calendar();
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                d = make_day(YEAR_W'($urandom), MONTH_W'($urandom), DOM_W'($urandom),
                             $urandom, $urandom, $urandom, $urandom, $urandom,
                             1'($urandom_range(0, 1)));
            else
            begin
                if (r < 11)
                    restart_calendar();
                else if (r < 90)
                    step_calendar($urandom_range(1, 3));
                else if (r < 95)
                    step_calendar($urandom_range(5, 45));
                d = walk_day($urandom_range(0, 39) == 0);
            end
            send_day(d);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        period_mode_we = 1'b0;
        period_mode_wdata = MODE_WEEK;
        day_if.valid = 1'b0;
        day_if.day_year = '0;
        day_if.day_month = '0;
        day_if.day_of_month = '0;
        day_if.day_open = '0;
        day_if.day_high = '0;
        day_if.day_low = '0;
        day_if.day_close = '0;
        day_if.day_volume = '0;
        day_if.last_day = 1'b0;
        idle_on = 1'b1;
        hold_request = 1'b0;
        quiet_cycles = 0;
        bar_mismatches = 0;
        bars_seen = 0;
        period_sel = MODE_WEEK;
        run_open = 1'b0;
        run_bar = '0;
        bar_count = '0;
        walk_y = 2000;
        walk_m = 1;
        walk_d = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_week_grouping();
        test_month_grouping();
        test_odd_dates();
        test_backpressure();
        test_random_traffic(MODE_WEEK, 400);
        test_random_traffic(MODE_MONTH, 400);
        test_random_traffic(MODE_SPARE_HI, 300);
        idle_on = 1'b0;
        test_random_traffic(MODE_MONTH, 250);
        test_random_traffic(MODE_WEEK, 250);

        day_if.valid <= 1'b0;
        while (bars_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bar_mismatches == 0 && bars_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
